>>> sv/console_line_editor_with_history_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the console line editor
// Shared forms of concurrent checks, clocked on the rising edge and
// disabled while the synchronous active-low reset is held.
// ---------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_WITH_HISTORY_MACROS_SVH
`define CONSOLE_LINE_EDITOR_WITH_HISTORY_MACROS_SVH

// Whenever ante holds in a cycle, cons holds in the same cycle.
`define CLE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("line editor check failed");

// Whenever ante holds in a cycle, cons holds in the following cycle.
`define CLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("line editor check failed");

`endif

>>> sv/cle_pkg.sv
// ---------------------------------------------------------------------------
// Console line editor package
// Result kinds, character codes, escape phases and the sequencer states.
// ---------------------------------------------------------------------------
package cle_pkg;

  typedef logic [1:0] cle_kind_t;

  localparam cle_kind_t KIND_ECHO  = 2'd0;
  localparam cle_kind_t KIND_ERASE = 2'd1;
  localparam cle_kind_t KIND_LINE  = 2'd2;
  localparam cle_kind_t KIND_END   = 2'd3;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_CSI      = 8'h5b;
  localparam logic [7:0] CH_PRINT_HI = 8'h7e;
  localparam logic [7:0] CH_DEL      = 8'h7f;

  typedef logic [1:0] cle_esc_t;

  localparam cle_esc_t ESC_NONE = 2'd0;
  localparam cle_esc_t ESC_SEEN = 2'd1;
  localparam cle_esc_t ESC_CSI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_LINE,
    ST_END,
    ST_ERASE,
    ST_ECHO
  } cle_state_t;

endpackage

>>> sv/cle_if.sv
// ---------------------------------------------------------------------------
// Console line editor channels
// Valid/ready channels for received bytes and for editor results.
// ---------------------------------------------------------------------------
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [4:0] line_length;
  logic       last;

  modport source (output valid, output kind, output out_byte, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input line_length,
                  input last, output ready);
endinterface

>>> sv/console_line_editor_with_history.sv
// ---------------------------------------------------------------------------
// Console line editor with history
// Edits one terminal line from received bytes, echoes edits, emits finished
// lines and recalls earlier lines with the up and down arrow sequences.
// ---------------------------------------------------------------------------
//
//   channel  | direction | payload                                | beat
//   ---------+-----------+----------------------------------------+--------------------
//   in_ch    | sink      | rx_byte                                | one received byte
//   out_ch   | source    | kind, out_byte, line_length, last      | one result
//
// A byte is taken in the idle state and decoded in the decode state, which waits
// while out_ch is stalled; a byte with one or no result finishes there. Line end
// and history browsing then produce one result per cycle while out_ch is ready,
// paced by the single read port of the line or history memory.
// A stall on out_ch holds the sequencer and the registered read data in place.
// Reset clears the control state only; both memories hold garbage until written.
// ---------------------------------------------------------------------------
`include "console_line_editor_with_history_macros.svh"

module console_line_editor_with_history #(
  parameter int LINE_CAP      = 32,
  parameter int HISTORY_DEPTH = 5
) (
  input logic       clk,
  input logic       rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);
  import cle_pkg::*;

  // Line length never exceeds LINE_CAP-1, history count reaches HISTORY_DEPTH.
  localparam int LEN_W   = $clog2(LINE_CAP);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W   = CNT_W + 1;
  localparam int HDEPTH  = HISTORY_DEPTH * LINE_CAP;
  localparam int HA_W    = (HDEPTH > 2) ? $clog2(HDEPTH) : 1;

  // Storage: the line being edited and the history ring, each a memory with
  // one write and one registered read per cycle. Lengths of the ring entries
  // are a handful of flops.
  logic [7:0]       line_mem [LINE_CAP];
  logic [7:0]       hist_mem [HDEPTH];
  logic [LEN_W-1:0] hlen_r   [HISTORY_DEPTH];
  logic [7:0]       line_rd_r;
  logic [7:0]       hist_rd_r;

  logic             line_we, line_re;
  logic [LEN_W-1:0] line_wa, line_ra;
  logic [7:0]       line_wd;
  logic             hist_we, hist_re;
  logic [HA_W-1:0]  hist_wa, hist_ra;
  logic             hlen_we;

  // Control state.
  cle_state_t        state_r, state_nxt;
  cle_esc_t          esc_r, esc_nxt;
  logic              cr_r, cr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  hcnt_r, hcnt_nxt;
  logic [SLOT_W-1:0] hnext_r, hnext_nxt;
  logic [CNT_W-1:0]  bpos_r, bpos_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the current byte.
  logic [7:0]        byte_r, byte_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  old_len_r, old_len_nxt;
  logic [LEN_W-1:0]  new_len_r, new_len_nxt;
  logic [HA_W-1:0]   hbase_r, hbase_nxt;

  // Output register.
  cle_kind_t         okind_r, okind_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic [4:0]        olen_r, olen_nxt;
  logic              olast_r, olast_nxt;

  // Ring slot of history position pos: the oldest entry sits at the next
  // write slot once the ring is full, and at slot zero before that.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [CNT_W-1:0]  pos,
                                                input logic [CNT_W-1:0]  cnt,
                                                input logic [SLOT_W-1:0] nxt);
    logic [SUM_W-1:0] start;
    logic [SUM_W-1:0] sum;
    start = (cnt == CNT_W'(HISTORY_DEPTH)) ? SUM_W'(nxt) : '0;
    sum   = start + SUM_W'(pos);
    if (sum >= SUM_W'(HISTORY_DEPTH)) begin
      sum = sum - SUM_W'(HISTORY_DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

  function automatic logic [HA_W-1:0] base_of(input logic [SLOT_W-1:0] slot);
    return HA_W'(HA_W'(slot) * HA_W'(LINE_CAP));
  endfunction

  logic              out_free;
  logic              key_up, key_dn, do_move;
  logic [CNT_W-1:0]  newp;
  logic [SLOT_W-1:0] nslot;
  logic [LEN_W-1:0]  nlen;
  logic [CNT_W-1:0]  cnt_after;
  logic              printable;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign key_up  = (byte_r == CH_UP);
  assign key_dn  = (byte_r == CH_DOWN);
  assign do_move = (key_up && bpos_r != '0) || (key_dn && bpos_r < hcnt_r);
  assign newp    = key_up ? CNT_W'(bpos_r - 1'b1) : CNT_W'(bpos_r + 1'b1);
  assign nslot   = slot_of(newp, hcnt_r, hnext_r);
  assign nlen    = (newp < hcnt_r) ? hlen_r[nslot] : '0;

  // Count after a non-empty line joins the ring; it saturates at the depth.
  assign cnt_after = (len_r != '0 && hcnt_r != CNT_W'(HISTORY_DEPTH)) ?
                     CNT_W'(hcnt_r + 1'b1) : hcnt_r;

  assign printable = (byte_r >= CH_PRINT_LO) && (byte_r <= CH_PRINT_HI);

  always_comb begin
    state_nxt     = state_r;
    esc_nxt       = esc_r;
    cr_nxt        = cr_r;
    len_nxt       = len_r;
    hcnt_nxt      = hcnt_r;
    hnext_nxt     = hnext_r;
    bpos_nxt      = bpos_r;
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    old_len_nxt   = old_len_r;
    new_len_nxt   = new_len_r;
    hbase_nxt     = hbase_r;
    okind_nxt     = okind_r;
    obyte_nxt     = obyte_r;
    olen_nxt      = olen_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    line_we = 1'b0;
    line_wa = len_r;
    line_wd = byte_r;
    line_re = 1'b0;
    line_ra = '0;
    hist_we = 1'b0;
    hist_wa = hbase_r + HA_W'(idx_r);
    hist_re = 1'b0;
    hist_ra = hbase_r;
    hlen_we = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          byte_nxt  = in_ch.rx_byte;
          state_nxt = ST_DEC;
        end
      end

      ST_DEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          priority if (esc_r == ESC_SEEN) begin
            esc_nxt = (byte_r == CH_CSI) ? ESC_CSI : ESC_NONE;
          end else if (esc_r == ESC_CSI) begin
            esc_nxt = ESC_NONE;
            if (do_move) begin
              // Erase the shown line, then echo the recalled one from the ring.
              bpos_nxt    = newp;
              old_len_nxt = len_r;
              new_len_nxt = nlen;
              len_nxt     = nlen;
              hbase_nxt   = base_of(nslot);
              idx_nxt     = '0;
              if (len_r != '0) begin
                state_nxt = ST_ERASE;
              end else if (nlen != '0) begin
                hist_re   = 1'b1;
                hist_ra   = base_of(nslot);
                state_nxt = ST_ECHO;
              end
            end
          end else if (byte_r == CH_LF && cr_r) begin
            cr_nxt = 1'b0;
          end else begin
            cr_nxt = (byte_r == CH_CR);
            if (byte_r == CH_CR || byte_r == CH_LF) begin
              hbase_nxt = base_of(hnext_r);
              idx_nxt   = '0;
              if (len_r != '0) begin
                line_re   = 1'b1;
                line_ra   = '0;
                state_nxt = ST_LINE;
              end else begin
                state_nxt = ST_END;
              end
            end else if (byte_r == CH_BS || byte_r == CH_DEL) begin
              if (len_r != '0) begin
                len_nxt       = LEN_W'(len_r - 1'b1);
                out_valid_nxt = 1'b1;
                okind_nxt     = KIND_ERASE;
                obyte_nxt     = '0;
                olen_nxt      = '0;
                olast_nxt     = 1'b1;
              end
            end else if (byte_r == CH_ESC) begin
              esc_nxt = ESC_SEEN;
            end else if (printable && len_r < LEN_W'(LINE_CAP - 1)) begin
              line_we       = 1'b1;
              len_nxt       = LEN_W'(len_r + 1'b1);
              out_valid_nxt = 1'b1;
              okind_nxt     = KIND_ECHO;
              obyte_nxt     = byte_r;
              olen_nxt      = '0;
              olast_nxt     = 1'b1;
            end
          end
        end
      end

      ST_LINE: begin
        // The read data holds while stalled because no new read is issued.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = KIND_LINE;
          obyte_nxt     = line_rd_r;
          olen_nxt      = '0;
          olast_nxt     = 1'b0;
          hist_we       = 1'b1;
          if (idx_r == LEN_W'(len_r - 1'b1)) begin
            state_nxt = ST_END;
          end else begin
            idx_nxt   = LEN_W'(idx_r + 1'b1);
            line_re   = 1'b1;
            line_ra   = LEN_W'(idx_r + 1'b1);
          end
        end
      end

      ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = KIND_END;
          obyte_nxt     = '0;
          olen_nxt      = 5'(len_r);
          olast_nxt     = 1'b1;
          if (len_r != '0) begin
            hlen_we   = 1'b1;
            hnext_nxt = (hnext_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 :
                        SLOT_W'(hnext_r + 1'b1);
          end
          hcnt_nxt  = cnt_after;
          bpos_nxt  = cnt_after;
          len_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_ERASE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = KIND_ERASE;
          obyte_nxt     = '0;
          olen_nxt      = '0;
          olast_nxt     = 1'b0;
          if (idx_r == LEN_W'(old_len_r - 1'b1)) begin
            idx_nxt = '0;
            if (new_len_r == '0) begin
              olast_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              hist_re   = 1'b1;
              hist_ra   = hbase_r;
              state_nxt = ST_ECHO;
            end
          end else begin
            idx_nxt = LEN_W'(idx_r + 1'b1);
          end
        end
      end

      ST_ECHO: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          okind_nxt     = KIND_ECHO;
          obyte_nxt     = hist_rd_r;
          olen_nxt      = '0;
          olast_nxt     = 1'b0;
          line_we       = 1'b1;
          line_wa       = idx_r;
          line_wd       = hist_rd_r;
          if (idx_r == LEN_W'(new_len_r - 1'b1)) begin
            olast_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = LEN_W'(idx_r + 1'b1);
            hist_re = 1'b1;
            hist_ra = hbase_r + HA_W'(LEN_W'(idx_r + 1'b1));
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      esc_r       <= ESC_NONE;
      cr_r        <= 1'b0;
      len_r       <= '0;
      hcnt_r      <= '0;
      hnext_r     <= '0;
      bpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      cr_r        <= cr_nxt;
      len_r       <= len_nxt;
      hcnt_r      <= hcnt_nxt;
      hnext_r     <= hnext_nxt;
      bpos_r      <= bpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    idx_r     <= idx_nxt;
    old_len_r <= old_len_nxt;
    new_len_r <= new_len_nxt;
    hbase_r   <= hbase_nxt;
    okind_r   <= okind_nxt;
    obyte_r   <= obyte_nxt;
    olen_r    <= olen_nxt;
    olast_r   <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    if (line_re) begin
      line_rd_r <= line_mem[line_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= line_rd_r;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hlen_we) begin
      hlen_r[hnext_r] <= len_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = okind_r;
  assign out_ch.out_byte    = obyte_r;
  assign out_ch.line_length = olen_r;
  assign out_ch.last        = olast_r;

  // The line never reaches its capacity, the browse position never passes
  // the history count, and the count saturates at the ring depth.
  `CLE_ASSERT_SAME(a_len_cap, clk, rst_n, 1'b1, len_r <= LEN_W'(LINE_CAP - 1))
  `CLE_ASSERT_SAME(a_bpos_cnt, clk, rst_n, 1'b1,
                   bpos_r <= hcnt_r && hcnt_r <= CNT_W'(HISTORY_DEPTH))
  // Streaming a line only runs on a non-empty line and inside its length.
  `CLE_ASSERT_SAME(a_line_idx, clk, rst_n, state_r == ST_LINE,
                   len_r != '0 && idx_r < len_r)
  // A line byte is always followed by more results, so it never closes a byte.
  `CLE_ASSERT_NEXT(a_line_not_last, clk, rst_n,
                   out_valid_nxt && okind_nxt == KIND_LINE, !olast_r)

endmodule

>>> tb/tb_console_line_editor_with_history.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the console line editor with history
// Sends received bytes into the editor and checks every result beat against
// a cycle-free copy of the editing rules: a short table of directed bytes
// comes first, then random typing, erasing, line ends, history browsing,
// broken escape sequences and noise, under varied back-pressure.
// ---------------------------------------------------------------------------
module tb_console_line_editor_with_history;
  import cle_pkg::*;

  localparam int LINE_CAP   = 32;
  localparam int HIST_DEPTH = 5;

  // The count of bytes sent, directed rows included, at which each
  // back-pressure phase ends.
  localparam int unsigned PHASE_A_END = 90;
  localparam int unsigned PHASE_B_END = 175;
  localparam int unsigned PHASE_C_END = 260;

  // A full history redraw is 62 beats plus its decode, so this
  // many quiet cycles at the end are enough for any stray beat to show up.
  localparam int DRAIN_CYCLES    = 80;
  // The long output hold must stay well under the watchdog limit.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int NUM_DIRECTED    = 25;

  // One result beat as the editor presents it on out_ch.
  typedef struct packed {
    cle_kind_t   kind;
    logic [7:0]  ch;
    logic [4:0]  len;
    logic        last;
  } editor_beat_t;

  // How a directed row is checked: against the line model, or against a
  // result typed into the table (no beat at all, or exactly one beat).
  typedef enum logic [1:0] {
    BY_MODEL,
    TYPED_NONE,
    TYPED_ONE
  } row_check_t;

  typedef struct packed {
    logic [7:0]   rx;
    row_check_t   how;
    editor_beat_t typed;
  } stim_row_t;

  localparam editor_beat_t NO_BEAT = '0;

  // Directed bytes. The typed rows are the ones whose result is obvious:
  // a line end on an empty line, dropped bytes, and single echo or erase beats.
  // Everything that depends on the stored line or the history uses the model.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{CH_CR,       TYPED_ONE,  '{KIND_END,   8'h00, 5'd0, 1'b1}}, // end of an empty line
    '{CH_LF,       TYPED_NONE, NO_BEAT},                          // LF right after CR
    '{CH_BS,       TYPED_NONE, NO_BEAT},                          // erase on an empty line
    '{CH_ESC,      TYPED_NONE, NO_BEAT},
    '{CH_CSI,      TYPED_NONE, NO_BEAT},
    '{CH_UP,       TYPED_NONE, NO_BEAT},                          // up with no history
    '{CH_PRINT_LO, TYPED_ONE,  '{KIND_ECHO,  8'h20, 5'd0, 1'b1}}, // lowest printable
    '{CH_PRINT_HI, TYPED_ONE,  '{KIND_ECHO,  8'h7e, 5'd0, 1'b1}}, // highest printable
    '{CH_DEL,      TYPED_ONE,  '{KIND_ERASE, 8'h00, 5'd0, 1'b1}},
    '{8'h80,       TYPED_NONE, NO_BEAT},                          // high half is dropped
    '{8'hff,       TYPED_NONE, NO_BEAT},
    '{CH_UP,       BY_MODEL,   NO_BEAT},                          // plain 'A' is printable
    '{CH_CR,       BY_MODEL,   NO_BEAT},                          // two-byte line to history
    '{CH_LF,       TYPED_NONE, NO_BEAT},
    '{CH_ESC,      TYPED_NONE, NO_BEAT},
    '{CH_CSI,      TYPED_NONE, NO_BEAT},
    '{CH_UP,       BY_MODEL,   NO_BEAT},                          // recall the stored line
    '{CH_ESC,      TYPED_NONE, NO_BEAT},
    '{CH_CSI,      TYPED_NONE, NO_BEAT},
    '{CH_UP,       BY_MODEL,   NO_BEAT},                          // already at the oldest
    '{CH_ESC,      TYPED_NONE, NO_BEAT},
    '{CH_CSI,      TYPED_NONE, NO_BEAT},
    '{CH_DOWN,     BY_MODEL,   NO_BEAT},                          // past the newest: erase
    '{CH_ESC,      TYPED_NONE, NO_BEAT},
    '{CH_CR,       TYPED_NONE, NO_BEAT}                           // CR eaten by the escape
  };

  logic clk = 1'b0;
  logic rst_n;

  cle_in_if  in_ch ();
  cle_out_if out_ch ();

  console_line_editor_with_history #(
    .LINE_CAP      (LINE_CAP),
    .HISTORY_DEPTH (HIST_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Line model: the editor's state as seen from outside, updated once per
  // accepted byte. The history ring keeps its write slot and fill count, and
  // recall_idx equals hist_used while no history entry is shown.
  // -------------------------------------------------------------------------
  cle_esc_t    esc_state  = ESC_NONE;
  bit          after_cr   = 1'b0;
  logic [7:0]  line_buf [LINE_CAP];
  int unsigned line_fill  = 0;
  logic [7:0]  hist_buf [HIST_DEPTH][LINE_CAP];
  int unsigned hist_fill [HIST_DEPTH];
  int unsigned hist_used  = 0;
  int unsigned hist_wr    = 0;
  int unsigned recall_idx = 0;

  // Beats caused by the byte just accepted, and all beats still owed by the editor.
  editor_beat_t step_beats [$];
  editor_beat_t editor_output_q [$];

  int unsigned err_count        = 0;
  int unsigned bytes_sent       = 0;
  int unsigned productive_bytes = 0;
  int unsigned beats_checked    = 0;
  int unsigned lines_completed  = 0;
  int unsigned longest_burst    = 0;
  int unsigned long_holds       = 0;
  int unsigned idle_cycles      = 0;

  int unsigned src_idle_pct = 28;
  int unsigned snk_idle_pct = 80;
  bit          hold_off_req = 1'b0;

  function automatic editor_beat_t make_beat(cle_kind_t k, logic [7:0] ch, logic [4:0] len);
    editor_beat_t b;
    b.kind = k;
    b.ch   = ch;
    b.len  = len;
    b.last = 1'b0;
    return b;
  endfunction

  // Applies one received byte to the line model and leaves its beats in step_beats.
  function automatic void line_editor_step(input logic [7:0] c);
    int unsigned newp;
    int unsigned old_len;
    int unsigned first;
    int unsigned s;
    int unsigned l;
    int unsigned i;
    step_beats.delete();
    if (esc_state == ESC_SEEN) begin
      // The byte after ESC is always consumed; only '[' keeps the sequence going.
      esc_state = (c == CH_CSI) ? ESC_CSI : ESC_NONE;
    end else if (esc_state == ESC_CSI) begin
      esc_state = ESC_NONE;
      if (c == CH_UP || c == CH_DOWN) begin
        newp = recall_idx;
        if (c == CH_UP && recall_idx > 0) begin
          newp = recall_idx - 1;
        end else if (c == CH_DOWN && recall_idx < hist_used) begin
          newp = recall_idx + 1;
        end
        if (newp != recall_idx) begin
          old_len    = line_fill;
          recall_idx = newp;
          if (newp >= hist_used) begin
            line_fill = 0;
          end else begin
            // Once the ring is full the oldest entry sits at the write slot.
            first = (hist_used == HIST_DEPTH) ? hist_wr : 0;
            s     = (first + newp) % HIST_DEPTH;
            l     = (hist_fill[s] > LINE_CAP - 1) ? LINE_CAP - 1 : hist_fill[s];
            for (i = 0; i < l; i++) begin
              line_buf[i] = hist_buf[s][i];
            end
            line_fill = l;
          end
          for (i = 0; i < old_len; i++) begin
            step_beats.push_back(make_beat(KIND_ERASE, 8'h00, 5'd0));
          end
          for (i = 0; i < line_fill; i++) begin
            step_beats.push_back(make_beat(KIND_ECHO, line_buf[i], 5'd0));
          end
        end
      end
    end else if (c == CH_LF && after_cr) begin
      after_cr = 1'b0;
    end else begin
      after_cr = (c == CH_CR);
      if (c == CH_CR || c == CH_LF) begin
        for (i = 0; i < line_fill; i++) begin
          step_beats.push_back(make_beat(KIND_LINE, line_buf[i], 5'd0));
        end
        step_beats.push_back(make_beat(KIND_END, 8'h00, 5'(line_fill)));
        lines_completed++;
        if (line_fill > 0) begin
          for (i = 0; i < line_fill; i++) begin
            hist_buf[hist_wr][i] = line_buf[i];
          end
          hist_fill[hist_wr] = line_fill;
          hist_wr = (hist_wr + 1) % HIST_DEPTH;
          if (hist_used < HIST_DEPTH) begin
            hist_used++;
          end
        end
        line_fill  = 0;
        recall_idx = hist_used;
      end else if (c == CH_BS || c == CH_DEL) begin
        if (line_fill > 0) begin
          line_fill--;
          step_beats.push_back(make_beat(KIND_ERASE, 8'h00, 5'd0));
        end
      end else if (c == CH_ESC) begin
        esc_state = ESC_SEEN;
      end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI && line_fill + 1 < LINE_CAP) begin
        // A printable byte on a full line falls through and is dropped.
        line_buf[line_fill] = c;
        line_fill++;
        step_beats.push_back(make_beat(KIND_ECHO, c, 5'd0));
      end
    end
    if (step_beats.size() > 0) begin
      step_beats[step_beats.size() - 1].last = 1'b1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Byte sender. It is entered and left at a falling edge. Random gaps drop
  // valid first; once valid is up it stays up until the beat is taken. The
  // line model is updated at the very edge that accepts the byte, so the
  // owed beats are queued before the editor can present any of them.
  // -------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input row_check_t how,
                           input editor_beat_t typed);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    line_editor_step(b);
    bytes_sent++;
    if (step_beats.size() > 0) begin
      productive_bytes++;
    end
    if (step_beats.size() > longest_burst) begin
      longest_burst = step_beats.size();
    end
    // Typed rows replace the model's beats; the model still moves its state.
    case (how)
      TYPED_NONE: ;
      TYPED_ONE:  editor_output_q.push_back(typed);
      default: begin
        foreach (step_beats[i]) begin
          editor_output_q.push_back(step_beats[i]);
        end
      end
    endcase
    @(negedge clk);
  endtask

  // Random traffic until the count of bytes sent reaches goal.
  // Most of it is well-formed: lines of printable text with the odd erase,
  // ended by CR, LF or CR LF, and complete arrow sequences. The rest is raw
  // noise and escape sequences that break off after ESC or after ESC '['.
  task automatic run_random_phase(input int unsigned goal);
    int unsigned n;
    int unsigned i;
    bit          long_line;
    while (bytes_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // Long lines skip the erases so that most of them run into the full-line limit.
          long_line = ($urandom_range(0, 5) == 0);
          n = long_line ? $urandom_range(29, 36) : $urandom_range(0, 10);
          for (i = 0; i < n; i++) begin
            if (!long_line && $urandom_range(0, 7) == 0) begin
              send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL, BY_MODEL, NO_BEAT);
            end else begin
              send_byte(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)), BY_MODEL, NO_BEAT);
            end
          end
          case ($urandom_range(0, 2))
            0: send_byte(CH_CR, BY_MODEL, NO_BEAT);
            1: send_byte(CH_LF, BY_MODEL, NO_BEAT);
            default: begin
              send_byte(CH_CR, BY_MODEL, NO_BEAT);
              send_byte(CH_LF, BY_MODEL, NO_BEAT);
            end
          endcase
        end
        5, 6: begin
          // Up is favored so that browsing reaches the oldest entries.
          repeat ($urandom_range(1, 4)) begin
            send_byte(CH_ESC, BY_MODEL, NO_BEAT);
            send_byte(CH_CSI, BY_MODEL, NO_BEAT);
            send_byte(($urandom_range(0, 9) < 6) ? CH_UP : CH_DOWN, BY_MODEL, NO_BEAT);
          end
        end
        7: begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom_range(0, 255)), BY_MODEL, NO_BEAT);
          end
        end
        8: begin
          send_byte(CH_ESC, BY_MODEL, NO_BEAT);
          send_byte(8'($urandom_range(0, 255)), BY_MODEL, NO_BEAT);
        end
        default: begin
          send_byte(CH_ESC, BY_MODEL, NO_BEAT);
          send_byte(CH_CSI, BY_MODEL, NO_BEAT);
          send_byte(8'($urandom_range(0, 255)), BY_MODEL, NO_BEAT);
        end
      endcase
    end
  endtask

  // -------------------------------------------------------------------------
  // Result receiver. Ready changes only at falling edges. On request it holds
  // ready low for a long stretch, counted here, while the sender keeps
  // offering bytes, so the editor backs up and stops taking input.
  // -------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        long_holds++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Every accepted result beat is compared field by field with the oldest
  // beat still owed. A beat with nothing owed is an error on its own.
  always @(posedge clk) begin
    editor_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_checked++;
      if (editor_output_q.size() == 0) begin
        $error("unexpected result beat: kind %0d out_byte 0x%02h line_length %0d last %0d",
               out_ch.kind, out_ch.out_byte, out_ch.line_length, out_ch.last);
        err_count++;
      end else begin
        want = editor_output_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          err_count++;
        end
        if (out_ch.out_byte !== want.ch) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.ch, out_ch.out_byte);
          err_count++;
        end
        if (out_ch.line_length !== want.len) begin
          $error("line_length: expected %0d, got %0d", want.len, out_ch.line_length);
          err_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          err_count++;
        end
      end
    end
  end

  // Cycles since the last beat on either channel. The long hold is the
  // longest quiet stretch a correct run can show, far below the limit.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("Watchdog: no beat on either channel for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence: reset, directed table, then three random phases, the idle
  // pattern swapped between sender and receiver and then off, and a final drain.
  // -------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase A: sender idles a little, receiver a lot.
    src_idle_pct = 28;
    snk_idle_pct = 80;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].how, directed_rows[i].typed);
    end
    run_random_phase(PHASE_A_END);

    // Phase B: the other way round.
    src_idle_pct = 80;
    snk_idle_pct = 28;
    run_random_phase(PHASE_B_END);

    // Phase C: no idling, opened by one long output hold.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_req = 1'b1;
    run_random_phase(PHASE_C_END);
    in_ch.valid <= 1'b0;

    while (editor_output_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d bytes sent, %0d with output, %0d result beats checked",
             bytes_sent, productive_bytes, beats_checked);
    $display("Summary: %0d lines ended, longest burst %0d beats, %0d long output hold(s)",
             lines_completed, longest_burst, long_holds);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
